### design/mfb_pkg.sv
package mfb_pkg;

    // Command codes carried on s_tuser
    localparam logic [2:0] CMD_PLOT  = 3'd0;
    localparam logic [2:0] CMD_BLIT  = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int        RECT_W    = 9;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BIT_ZERO  = 8'h01;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_READ0  = 7'b0000100,
        ST_WRITE0 = 7'b0001000,
        ST_WRITE1 = 7'b0010000,
        ST_CLEAR  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // Frame store port strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    // Dirty zone operations
    typedef struct packed {
        logic mark;
        logic clear;
    } zone_op_t;

endpackage

### design/mfb_store.sv
module mfb_store #(
    parameter int DEPTH = 8192,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  mfb_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [7:0]          wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [7:0]          rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mfb_zone.sv
module mfb_zone #(
    parameter int XW        = 9,
    parameter int YW        = 9,
    parameter int RST_LEFT  = 200,
    parameter int RST_TOP   = 200
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfb_pkg::zone_op_t               op,
    input  logic [XW-1:0]                   px,
    input  logic [YW-1:0]                   py,
    input  logic [XW-1:0]                   wpix,
    input  logic [YW-1:0]                   hgt,
    output logic [mfb_pkg::RECT_W-1:0]      rect_left,
    output logic [mfb_pkg::RECT_W-1:0]      rect_top,
    output logic [mfb_pkg::RECT_W-1:0]      rect_right,
    output logic [mfb_pkg::RECT_W-1:0]      rect_bottom,
    output logic                            rect_clean
);

    logic [XW-1:0] left_reg, left_next;
    logic [YW-1:0] top_reg, top_next;
    logic [XW-1:0] right_reg, right_next;
    logic [YW-1:0] bottom_reg, bottom_next;
    logic          clean_reg, clean_next;
    logic [XW-1:0] right_grow;
    logic [YW-1:0] bottom_grow;
    logic [XW-1:0] right_pad;

    // Grow the zone around the point, then clamp to the display; a clear resets it
    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        clean_next  = clean_reg;
        right_grow  = (right_reg < px) ? px : right_reg;
        bottom_grow = (bottom_reg < py) ? py : bottom_reg;
        if (op.clear)
        begin
            left_next   = wpix;
            top_next    = hgt;
            right_next  = '0;
            bottom_next = '0;
            clean_next  = 1'b1;
        end
        else if (op.mark)
        begin
            if (px < left_reg)
            begin
                left_next  = px;
                clean_next = 1'b0;
            end
            if (py < top_reg)
            begin
                top_next   = py;
                clean_next = 1'b0;
            end
            if (right_reg < px || right_grow > wpix)
            begin
                clean_next = 1'b0;
            end
            if (bottom_reg < py || bottom_grow > hgt)
            begin
                clean_next = 1'b0;
            end
            right_next  = (right_grow > wpix) ? wpix : right_grow;
            bottom_next = (bottom_grow > hgt) ? hgt : bottom_grow;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= XW'(RST_LEFT);
            top_reg    <= YW'(RST_TOP);
            right_reg  <= '0;
            bottom_reg <= '0;
            clean_reg  <= 1'b1;
        end
        else
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            clean_reg  <= clean_next;
        end
    end

    // Report left and right edges rounded to whole bytes, zeros while clean
    assign right_pad = right_reg + XW'(8);

    always_comb
    begin
        if (clean_reg)
        begin
            rect_left   = '0;
            rect_top    = '0;
            rect_right  = '0;
            rect_bottom = '0;
        end
        else
        begin
            rect_left   = mfb_pkg::RECT_W'({left_reg[XW-1:3], 3'b000});
            rect_top    = mfb_pkg::RECT_W'(top_reg);
            rect_right  = mfb_pkg::RECT_W'({right_pad[XW-1:3], 3'b000});
            rect_bottom = mfb_pkg::RECT_W'(bottom_reg);
        end
    end

    assign rect_clean = clean_reg;

endmodule

### design/mono_framebuffer_blit_engine.sv
// One-bit-per-pixel framebuffer with a dirty rectangle.
// Input stream (s_*): one beat is one command; s_tuser carries the command,
// s_tdata carries x, y and the blit pattern. Output stream (m_*): exactly one
// beat per command with the read byte and the dirty zone.
// Configuration: APB-style port, width_bytes at 0x0 and height_rows at 0x4.
// One command is in work at a time; s_tready is high only while the
// sequencer waits for a command, so the next command is taken at the earliest
// in the cycle after its predecessor's result is loaded. The frame store has one
// read and one write port; each target byte is one read and one masked write-back.
// After reset the sequencer sweeps the frame store to white, one byte per
// cycle (all MAX_WIDTH_BYTES*MAX_HEIGHT_ROWS bytes, 8192 by default), before the
// first command is taken; configuration writes are taken meanwhile.
// The result sits in an output register, so the next command is accepted
// and worked on while m_tready is low; the sequencer holds its finished
// result only when the previous beat has not been taken yet.
module mono_framebuffer_blit_engine #(
    parameter int MAX_WIDTH_BYTES = 32,
    parameter int MAX_HEIGHT_ROWS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_pos[11:0], y_pos[23:12], pattern[31:24]
    input  logic [2:0]  s_tuser,   // command[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], rect_left[16:8], rect_top[25:17], rect_right[34:26],
    // rect_bottom[43:35], zero fill[47:44]
    output logic [47:0] m_tdata,
    output logic        m_tuser    // rect_clean
);

    localparam int DEPTH = MAX_WIDTH_BYTES * MAX_HEIGHT_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WBW   = $clog2(MAX_WIDTH_BYTES + 1);
    localparam int HBW   = $clog2(MAX_HEIGHT_ROWS + 1);
    localparam int RW    = $clog2(MAX_HEIGHT_ROWS);
    localparam int XW    = $clog2(MAX_WIDTH_BYTES * 8 + 9);
    localparam int RST_W = (MAX_WIDTH_BYTES < 25) ? MAX_WIDTH_BYTES : 25;
    localparam int RST_H = (MAX_HEIGHT_ROWS < 200) ? MAX_HEIGHT_ROWS : 200;
    localparam int RW_ = mfb_pkg::RECT_W;

    mfb_pkg::state_t   state_reg, state_next;
    mfb_pkg::mem_ctl_t mem_ctl;
    mfb_pkg::zone_op_t zone_op;

    logic [5:0]        width_reg;
    logic [8:0]        height_reg;
    logic              cfg_wr;

    logic [2:0]        cmd_reg;
    logic [11:0]       x_reg;
    logic [11:0]       y_reg;
    logic [7:0]        pat_reg;

    logic [WBW-1:0]    col_reg, col_next, col_inc;
    logic [RW-1:0]     row_reg, row_next;
    logic [AW-1:0]     addr_reg, addr_next, addr_inc;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic              boot_reg, boot_next;
    logic [7:0]        rd_byte_reg, rd_byte_next;
    logic [RW+WBW-1:0] prod;

    logic [WBW-1:0]    w_eff;
    logic [HBW-1:0]    h_eff;
    logic [XW-1:0]     wpix;
    logic              on_display;
    logic [2:0]        sh;
    logic [7:0]        lmask;
    logic [7:0]        rmask;
    logic [7:0]        dot_mask;

    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic [XW-1:0]     px;

    logic [RW_-1:0]    rect_left, rect_top, rect_right, rect_bottom;
    logic              rect_clean;

    logic              out_valid_reg;
    logic [47:0]       out_data_reg;
    logic              out_clean_reg;
    logic              out_load;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 6'd25;
            height_reg <= 9'd200;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                mfb_pkg::REG_WIDTH:  width_reg  <= pwdata[5:0];
                mfb_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mfb_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            mfb_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // Saturate the display size to the store; a zero size reads as one
    always_comb
    begin
        if (width_reg == 6'd0)
        begin
            w_eff = WBW'(1);
        end
        else if (7'(width_reg) > 7'(MAX_WIDTH_BYTES))
        begin
            w_eff = WBW'(MAX_WIDTH_BYTES);
        end
        else
        begin
            w_eff = WBW'(width_reg);
        end
        if (height_reg == 9'd0)
        begin
            h_eff = HBW'(1);
        end
        else if (11'(height_reg) > 11'(MAX_HEIGHT_ROWS))
        begin
            h_eff = HBW'(MAX_HEIGHT_ROWS);
        end
        else
        begin
            h_eff = HBW'(height_reg);
        end
    end

    assign wpix = XW'({w_eff, 3'b000});

    // Decode the latched command position
    assign on_display = !x_reg[11] && !y_reg[11]
                        && ({1'b0, x_reg[10:0]} < 12'(wpix))
                        && ({1'b0, y_reg[10:0]} < 12'(h_eff));
    assign col_next  = WBW'(x_reg[10:3]);
    assign row_next  = RW'(y_reg[10:0]);
    assign prod      = row_next * w_eff;
    assign addr_next = AW'(prod) + AW'(col_next);
    assign addr_inc  = addr_reg + AW'(1);
    assign col_inc   = col_reg + WBW'(1);

    // Byte masks for the bit offset
    assign sh       = x_reg[2:0];
    assign lmask    = (pat_reg << sh) | (mfb_pkg::BYTE_ONES >> (4'd8 - {1'b0, sh}));
    assign rmask    = (pat_reg >> (4'd8 - {1'b0, sh})) | (mfb_pkg::BYTE_ONES << sh);
    assign dot_mask = ~(mfb_pkg::BIT_ZERO << sh);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        boot_next    = boot_reg;
        rd_byte_next = rd_byte_reg;
        mem_ctl      = '0;
        zone_op      = '0;
        wr_addr      = addr_reg;
        wr_data      = rd_data;
        rd_addr      = addr_reg;
        px           = XW'({col_reg, 3'b000});
        out_load     = 1'b0;
        case (state_reg)
            mfb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mfb_pkg::ST_DECODE;
                end
            end
            mfb_pkg::ST_DECODE:
            begin
                rd_byte_next = '0;
                case (cmd_reg)
                    mfb_pkg::CMD_CLEAR:
                    begin
                        cnt_next   = '0;
                        state_next = mfb_pkg::ST_CLEAR;
                    end
                    mfb_pkg::CMD_PLOT, mfb_pkg::CMD_BLIT, mfb_pkg::CMD_READ:
                    begin
                        state_next = on_display ? mfb_pkg::ST_READ0 : mfb_pkg::ST_DONE;
                    end
                    default:
                    begin
                        state_next = mfb_pkg::ST_DONE;
                    end
                endcase
            end
            mfb_pkg::ST_READ0:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = mfb_pkg::ST_WRITE0;
            end
            mfb_pkg::ST_WRITE0:
            begin
                state_next = mfb_pkg::ST_DONE;
                case (cmd_reg)
                    mfb_pkg::CMD_PLOT:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        wr_data       = rd_data & dot_mask;
                        zone_op.mark  = 1'b1;
                    end
                    mfb_pkg::CMD_BLIT:
                    begin
                        mem_ctl.wr_en = 1'b1;
                        wr_data       = rd_data & lmask;
                        zone_op.mark  = 1'b1;
                        if (col_inc < w_eff)
                        begin
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = addr_inc;
                            state_next    = mfb_pkg::ST_WRITE1;
                        end
                    end
                    mfb_pkg::CMD_READ:
                    begin
                        rd_byte_next = rd_data;
                    end
                    default:
                    begin
                        rd_byte_next = '0;
                    end
                endcase
            end
            mfb_pkg::ST_WRITE1:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = addr_inc;
                wr_data       = rd_data & rmask;
                zone_op.mark  = 1'b1;
                px            = XW'({col_inc, 3'b000});
                state_next    = mfb_pkg::ST_DONE;
            end
            mfb_pkg::ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = cnt_reg;
                wr_data       = mfb_pkg::BYTE_ONES;
                cnt_next      = cnt_reg + AW'(1);
                if (cnt_reg == AW'(DEPTH - 1))
                begin
                    boot_next = 1'b0;
                    if (boot_reg)
                    begin
                        state_next = mfb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        zone_op.clear = 1'b1;
                        state_next    = mfb_pkg::ST_DONE;
                    end
                end
            end
            mfb_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mfb_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == mfb_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfb_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            boot_reg  <= boot_next;
        end
    end

    // Latch the command beat and its decoded address
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            x_reg   <= s_tdata[11:0];
            y_reg   <= s_tdata[23:12];
            pat_reg <= s_tdata[31:24];
        end
        if (state_reg == mfb_pkg::ST_DECODE)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            addr_reg <= addr_next;
        end
        rd_byte_reg <= rd_byte_next;
    end

    mfb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mfb_zone #(
        .XW       (XW),
        .YW       (HBW),
        .RST_LEFT (RST_W * 8),
        .RST_TOP  (RST_H)
    ) u_zone (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (zone_op),
        .px          (px),
        .py          (HBW'(row_reg)),
        .wpix        (wpix),
        .hgt         (h_eff),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .rect_clean  (rect_clean)
    );

    // Output register: load the result, drop valid once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg  <= {4'b0000, rect_bottom, rect_right, rect_top, rect_left,
                              rd_byte_reg};
            out_clean_reg <= rect_clean;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_clean_reg;

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int         MAX_W       = 32;
    localparam int         MAX_H       = 256;
    localparam int         STORE_BYTES = MAX_W * MAX_H;
    localparam logic [2:0] CMD_QUERY   = 3'd4;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 55;
    localparam int         LONG_HOLD   = 400;

    typedef struct {
        logic [2:0]         op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic [7:0]         pat;
        bit                 drain;
    } draw_cmd_t;

    typedef struct {
        logic [7:0] rd;
        logic [8:0] left;
        logic [8:0] top;
        logic [8:0] right;
        logic [8:0] bottom;
        logic       clean;
    } zone_report_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // x_pos[11:0], y_pos[23:12], pattern[31:24]
    logic [2:0]  s_tuser  = '0;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // read_data[7:0], rect_left[16:8], rect_top[25:17], rect_right[34:26],
    // rect_bottom[43:35], zero fill[47:44]
    logic [47:0] m_tdata;
    logic        m_tuser;         // rect_clean

    // shadow copy of the block
    logic [7:0]  shadow_fb [STORE_BYTES];
    logic [5:0]  width_reg;
    logic [8:0]  height_reg;
    int unsigned zone_l, zone_t, zone_r, zone_b;
    bit          zone_clean;

    draw_cmd_t    cmd_q[$];
    zone_report_t report_q[$];
    draw_cmd_t    live_cmd;
    int           send_gap   = 0;
    int           ready_gap  = 0;
    int           hold_left  = 0;
    int           hold_req   = 0;
    bit           send_idle  = 1'b0;
    bit           recv_idle  = 1'b0;
    int           clears_left = 6;
    int           err_count  = 0;

    mono_framebuffer_blit_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    // saturate the registers to the supported display size
    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_H)
            return MAX_H;
        return height_reg;
    endfunction

    function automatic void zone_reset();
        zone_l     = eff_width() * 8;
        zone_t     = eff_height();
        zone_r     = 0;
        zone_b     = 0;
        zone_clean = 1'b1;
    endfunction

    // grow the zone around one point, then clamp to the display
    function automatic void zone_mark(int unsigned px, int unsigned py);
        int unsigned wpix;
        int unsigned h;
        wpix = eff_width() * 8;
        h    = eff_height();
        if (px < zone_l)
        begin
            zone_l = px;
            zone_clean = 1'b0;
        end
        if (py < zone_t)
        begin
            zone_t = py;
            zone_clean = 1'b0;
        end
        if (zone_r < px)
        begin
            zone_r = px;
            zone_clean = 1'b0;
        end
        if (zone_b < py)
        begin
            zone_b = py;
            zone_clean = 1'b0;
        end
        if (zone_r > wpix)
        begin
            zone_r = wpix;
            zone_clean = 1'b0;
        end
        if (zone_b > h)
        begin
            zone_b = h;
            zone_clean = 1'b0;
        end
    endfunction

    // update the shadow framebuffer and queue the zone report of one command
    function automatic void apply_command(draw_cmd_t c);
        int           xs;
        int           ys;
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  sh;
        int unsigned  addr;
        int unsigned  lmask;
        int unsigned  rmask;
        bit           on_screen;
        zone_report_t r;
        xs = c.x;
        ys = c.y;
        w  = eff_width();
        h  = eff_height();
        on_screen = xs >= 0 && ys >= 0 && xs < int'(w * 8) && ys < int'(h);
        col  = on_screen ? xs / 8 : 0;
        sh   = on_screen ? xs % 8 : 0;
        addr = on_screen ? (ys * w + col) % STORE_BYTES : 0;
        r.rd = '0;
        case (c.op)
            mfb_pkg::CMD_PLOT:
            begin
                if (on_screen)
                begin
                    shadow_fb[addr] = shadow_fb[addr] & ~(8'h01 << sh);
                    zone_mark(col * 8, ys);
                end
            end
            mfb_pkg::CMD_BLIT:
            begin
                if (on_screen)
                begin
                    lmask = ((c.pat << sh) | (32'hFF >> (8 - sh))) & 32'hFF;
                    rmask = ((c.pat >> (8 - sh)) | (32'hFF << sh)) & 32'hFF;
                    shadow_fb[addr] = shadow_fb[addr] & lmask[7:0];
                    zone_mark(col * 8, ys);
                    // skip the right byte at the row end
                    if (col + 1 < w)
                    begin
                        shadow_fb[(addr + 1) % STORE_BYTES] =
                            shadow_fb[(addr + 1) % STORE_BYTES] & rmask[7:0];
                        zone_mark((col + 1) * 8, ys);
                    end
                end
            end
            mfb_pkg::CMD_CLEAR:
            begin
                foreach (shadow_fb[i])
                    shadow_fb[i] = 8'hFF;
                zone_reset();
            end
            mfb_pkg::CMD_READ:
            begin
                if (on_screen)
                    r.rd = shadow_fb[addr];
            end
            default:
            begin
            end
        endcase
        if (zone_clean)
        begin
            r.left   = '0;
            r.top    = '0;
            r.right  = '0;
            r.bottom = '0;
            r.clean  = 1'b1;
        end
        else
        begin
            r.left   = 9'(zone_l & ~32'd7);
            r.top    = 9'(zone_t);
            r.right  = 9'((zone_r + 8) & ~32'd7);
            r.bottom = 9'(zone_b);
            r.clean  = 1'b0;
        end
        report_q.push_back(r);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            err_count++;
        end
    endfunction

    // command driver: one beat per queued command, random gap after each while send_idle is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_command(live_cmd);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0 && !(cmd_q[0].drain && report_q.size() != 0))
                begin
                    live_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= live_cmd.op;
                    s_tdata  <= {live_cmd.pat, live_cmd.y, live_cmd.x};
                    send_gap = send_idle ? $urandom_range(0, 13) : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: check each beat, stall at random or for a long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    err_count++;
                end
                else
                begin
                    check_field("read_data",   report_q[0].rd,     m_tdata[7:0]);
                    check_field("rect_left",   report_q[0].left,   m_tdata[16:8]);
                    check_field("rect_top",    report_q[0].top,    m_tdata[25:17]);
                    check_field("rect_right",  report_q[0].right,  m_tdata[34:26]);
                    check_field("rect_bottom", report_q[0].bottom, m_tdata[43:35]);
                    check_field("rect_clean",  report_q[0].clean,  m_tuser);
                    void'(report_q.pop_front());
                end
                ready_gap = recv_idle ? $urandom_range(0, 13) : 0;
            end
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (ready_gap != 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mfb_pkg::REG_WIDTH)
            width_reg = val[5:0];
        else
            height_reg = val[8:0];
    endtask

    // hold until every queued command has produced its result
    task automatic wait_drain();
        @(negedge clk);
        while (cmd_q.size() != 0 || s_tvalid || report_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_cmd(input logic [2:0] op, input int x, input int y,
                            input logic [7:0] pat, input bit drain);
        draw_cmd_t c;
        c.op    = op;
        c.x     = 12'(x);
        c.y     = 12'(y);
        c.pat   = pat;
        c.drain = drain;
        cmd_q.push_back(c);
    endtask

    // mostly on-screen commands, some clustered, some off-screen or raw noise
    function automatic draw_cmd_t random_draw(bit drain);
        draw_cmd_t   c;
        int unsigned pick;
        int unsigned wpix;
        int unsigned h;
        wpix = eff_width() * 8;
        h    = eff_height();
        pick = $urandom_range(0, 99);
        if (pick < 32)
            c.op = mfb_pkg::CMD_PLOT;
        else if (pick < 64)
            c.op = mfb_pkg::CMD_BLIT;
        else if (pick < 88)
            c.op = mfb_pkg::CMD_READ;
        else if (pick < 98)
            c.op = CMD_QUERY + 3'($urandom_range(0, 3));
        else if (clears_left != 0)
        begin
            c.op = mfb_pkg::CMD_CLEAR;
            clears_left--;
        end
        else
            c.op = mfb_pkg::CMD_READ;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            c.x = 12'($urandom);
            c.y = 12'($urandom);
        end
        else if (pick < 5)
        begin
            c.x = 12'($urandom_range(0, wpix < 64 ? wpix - 1 : 63));
            c.y = 12'($urandom_range(0, h < 12 ? h - 1 : 11));
        end
        else
        begin
            c.x = 12'(int'($urandom_range(0, wpix + 5)) - 3);
            c.y = 12'(int'($urandom_range(0, h + 3)) - 2);
        end
        c.pat   = 8'($urandom);
        c.drain = drain;
        return c;
    endfunction

    initial
    begin
        int          p;
        int          i;
        logic [31:0] widths [PHASES];
        logic [31:0] heights [PHASES];
        widths  = '{32, 1, 0, 63, 33, 7, 25, 16};
        heights = '{256, 1, 0, 511, 257, 13, 200, 100};
        foreach (shadow_fb[k])
            shadow_fb[k] = 8'hFF;
        width_reg  = 6'd25;
        height_reg = 9'd200;
        zone_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the largest display
        reg_write(mfb_pkg::REG_WIDTH, 32);
        reg_write(mfb_pkg::REG_HEIGHT, 256);
        push_cmd(mfb_pkg::CMD_READ,      0,     0, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,      0,     0, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,    255,   255, 8'hFF, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,     -1,     5, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,    256,     5, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,      5,   256, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,   2047,  2047, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_PLOT,  -2048, -2048, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,      3,    10, 8'h5A, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,    248,    20, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,     16,    30, 8'h0F, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,     -1,    30, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,      0,    10, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,      8,    10, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,    248,    20, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,     -8,     0, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,    256,     0, 8'h00, 1'b0);
        push_cmd(CMD_QUERY,              0,     0, 8'h00, 1'b0);
        push_cmd(CMD_QUERY + 3'd3,       0,     0, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_CLEAR,     0,     0, 8'h00, 1'b1);
        push_cmd(CMD_QUERY,              0,     0, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,    100,   255, 8'hFF, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,     96,   255, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_BLIT,    101,   255, 8'h00, 1'b0);
        push_cmd(mfb_pkg::CMD_READ,    104,   255, 8'h00, 1'b0);
        wait_drain();

        // random phases across display sizes, idling varied per phase
        for (p = 0; p < PHASES; p++)
        begin
            reg_write(mfb_pkg::REG_WIDTH, widths[p]);
            reg_write(mfb_pkg::REG_HEIGHT, heights[p]);
            @(negedge clk);
            send_idle = p[0] | p[2];
            recv_idle = p[1] | p[2];
            if (p == 0)
                hold_req = LONG_HOLD;
            for (i = 0; i < PHASE_ITEMS; i++)
                cmd_q.push_back(random_draw(i == PHASE_ITEMS / 2));
            wait_drain();
        end

        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
